[rtl/ffba_pkg.sv]
// Package with the shared codes and the sequencer state type of the first-fit allocator.
package ffba_pkg;

    // Width of block offsets and sizes, fixed by the 16-bit request and result fields.
    localparam int ADDR_BITS = 16;

    // Request types.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HEAP_SIZE   = 2'd0;
    localparam logic [1:0] CFG_HEADER_SIZE = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [15:0] HEAP_SIZE_RST   = 16'd1024;
    localparam logic [7:0]  HEADER_SIZE_RST = 8'd24;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_SH_RD,
        S_SH_WR,
        S_SPL_REM,
        S_SPL_CUR,
        S_F_RD,
        S_F_CHK,
        S_F_NRD,
        S_F_NCHK,
        S_F_S1,
        S_F_S2,
        S_F_WR,
        S_RM_RD,
        S_RM_WR,
        S_RESP
    } state_t;

endpackage

[rtl/first_fit_block_allocator_unit.sv]
// First-fit block allocator: a sequencer over a block table RAM, with split and coalesce.
//
// The block keeps an address-ordered table of blocks (header offset, payload size, free mark)
// in one RAM of MAX_BLOCKS entries with a registered read port, and handles one transaction at
// a time while stalling its input. Every step goes through that one RAM, so the cost is
// set by the table walk: an allocate scans the entries up to the first fit and, on a split, moves
// every later entry; a free scans the entries up to the match and moves every later entry when
// neighbors are merged. After reset and after a write to the heap size or header size register
// in the idle or init state, the table returns to a single free block at offset 0 before the
// next transaction is accepted. Results sit in an output register, so a new transaction may be
// taken while the last result waits.
module first_fit_block_allocator_unit
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    // Request channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] req_size,
    input  logic [15:0] req_addr,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] block_addr
);

    localparam int AW   = ADDR_BITS;
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int NW   = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = ((AW > 16) ? AW : 16) + 1;
    localparam int EW   = 2 * AW + 1;
    localparam logic [NW:0] MAX_CNT = (NW + 1)'(MAX_BLOCKS);

    state_t state_reg, state_next;

    logic [15:0]   heap_reg;
    logic [7:0]    hdr_reg;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] idx_reg;
    logic [NW-1:0] k_reg;
    logic [15:0]   rsize_reg;
    logic [15:0]   raddr_req_reg;
    logic [AW-1:0] cur_off_reg;
    logic [AW-1:0] cur_size_reg;
    logic [AW-1:0] prev_off_reg;
    logic [AW-1:0] prev_size_reg;
    logic          prev_free_reg;
    logic [AW-1:0] nxt_size_reg;
    logic          nxt_free_reg;
    logic [AW-1:0] merge_reg;
    logic [NW-1:0] j_reg;
    logic [1:0]    r_reg;
    logic [1:0]    res_status_reg;
    logic [15:0]   res_addr_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [15:0]   out_addr_reg;

    // RAM port signals.
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    ffba_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Fields of the entry read last cycle.
    logic          e_free;
    logic [AW-1:0] e_size;
    logic [AW-1:0] e_off;
    assign e_free = ram_rdata[EW-1];
    assign e_size = ram_rdata[2*AW-1:AW];
    assign e_off  = ram_rdata[AW-1:0];

    // Wide views for compares and sums.
    logic [CW-1:0] e_size_w, e_off_w, req_w, hdr_w, left_w, cur_off_w, cur_size_w;
    logic [CW-1:0] rem_off_w, s1_w, s2_w, init_w, addr_w;
    logic          fit;
    assign e_size_w   = {{(CW-AW){1'b0}}, e_size};
    assign e_off_w    = {{(CW-AW){1'b0}}, e_off};
    assign req_w      = {{(CW-16){1'b0}}, rsize_reg};
    assign addr_w     = {{(CW-16){1'b0}}, raddr_req_reg};
    assign hdr_w      = {{(CW-8){1'b0}}, hdr_reg};
    assign cur_off_w  = {{(CW-AW){1'b0}}, cur_off_reg};
    assign cur_size_w = {{(CW-AW){1'b0}}, cur_size_reg};
    assign left_w     = e_size_w - req_w;
    assign fit        = e_free && (e_size_w >= req_w) && (left_w >= hdr_w);
    assign rem_off_w  = cur_off_w + hdr_w + req_w;
    assign s1_w       = {{(CW-AW){1'b0}}, prev_size_reg} + cur_size_w + hdr_w;
    assign s2_w       = {{(CW-AW){1'b0}}, merge_reg} + {{(CW-AW){1'b0}}, nxt_size_reg} + hdr_w;
    assign init_w     = (heap_reg > {8'd0, hdr_reg})
                        ? {{(CW-16){1'b0}}, heap_reg - {8'd0, hdr_reg}} : '0;

    // Loop bounds.
    logic [NW:0] idx_ext, idx_p1, k_ext, kr_sum, count_ext;
    assign idx_ext   = {1'b0, idx_reg};
    assign idx_p1    = idx_ext + 1'b1;
    assign k_ext     = {1'b0, k_reg};
    assign kr_sum    = k_ext + {{(NW-1){1'b0}}, r_reg};
    assign count_ext = {1'b0, count_reg};

    logic cfg_hit;
    assign cfg_hit = cfg_wr_en && ((cfg_index == CFG_HEAP_SIZE) || (cfg_index == CFG_HEADER_SIZE));

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    // Size of the free remainder of a split block.
    function automatic logic [AW-1:0] s2_rem(input logic [CW-1:0] size_w);
        logic [CW-1:0] diff;
        diff = size_w - req_w - hdr_w;
        return diff[AW-1:0];
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:    state_next = cfg_hit ? S_INIT : S_IDLE;
            S_IDLE:
            begin
                if (cfg_hit)
                    state_next = S_INIT;
                else if (!cfg_wr_en && in_valid)
                    state_next = (req_type == REQ_ALLOC) ? S_A_RD : S_F_RD;
            end
            S_A_RD:    state_next = (idx_ext >= count_ext) ? S_RESP : S_A_CHK;
            S_A_CHK:
            begin
                if (!fit)
                    state_next = S_A_RD;
                else if (left_w == hdr_w || count_ext >= MAX_CNT)
                    state_next = S_RESP;
                else
                    state_next = S_SH_RD;
            end
            S_SH_RD:   state_next = (k_ext > idx_p1) ? S_SH_WR : S_SPL_REM;
            S_SH_WR:   state_next = S_SH_RD;
            S_SPL_REM: state_next = S_SPL_CUR;
            S_SPL_CUR: state_next = S_RESP;
            S_F_RD:    state_next = (idx_ext >= count_ext) ? S_RESP : S_F_CHK;
            S_F_CHK:   state_next = (e_off_w == addr_w) ? S_F_NRD : S_F_RD;
            S_F_NRD:   state_next = (idx_p1 < count_ext) ? S_F_NCHK : S_F_S1;
            S_F_NCHK:  state_next = S_F_S1;
            S_F_S1:    state_next = S_F_S2;
            S_F_S2:    state_next = S_F_WR;
            S_F_WR:    state_next = S_RM_RD;
            S_RM_RD:   state_next = (r_reg != 2'd0 && kr_sum < count_ext) ? S_RM_WR : S_RESP;
            S_RM_WR:   state_next = S_RM_RD;
            S_RESP:    state_next = out_free ? S_IDLE : S_RESP;
            default:   state_next = S_INIT;
        endcase
    end

    // RAM controls and the input stall.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IW-1:0];
        ram_wdata = {1'b0, e_size, e_off};
        ram_raddr = idx_reg[IW-1:0];
        in_stall  = (state_reg != S_IDLE) || cfg_wr_en;
        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {1'b1, init_w[AW-1:0], {AW{1'b0}}};
            end
            S_A_CHK:
            begin
                ram_we = fit && (left_w == hdr_w || count_ext >= MAX_CNT);
            end
            S_SH_RD:
            begin
                ram_raddr = k_reg[IW-1:0] - 1'b1;
            end
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[IW-1:0];
                ram_wdata = ram_rdata;
            end
            S_SPL_REM:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_p1[IW-1:0];
                ram_wdata = {1'b1, s2_rem(cur_size_w), rem_off_w[AW-1:0]};
            end
            S_SPL_CUR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, req_w[AW-1:0], cur_off_reg};
            end
            S_F_NRD:
            begin
                ram_raddr = idx_p1[IW-1:0];
            end
            S_F_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[IW-1:0];
                ram_wdata = {1'b1, merge_reg, (r_reg != 2'd0 && prev_free_reg)
                             ? prev_off_reg : cur_off_reg};
            end
            S_RM_RD:
            begin
                ram_raddr = kr_sum[IW-1:0];
            end
            S_RM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[IW-1:0];
                ram_wdata = ram_rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            heap_reg      <= HEAP_SIZE_RST;
            hdr_reg       <= HEADER_SIZE_RST;
            count_reg     <= NW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_IDLE || state_reg == S_INIT) && cfg_wr_en)
            begin
                if (cfg_index == CFG_HEAP_SIZE)
                    heap_reg <= cfg_wr_data;
                else if (cfg_index == CFG_HEADER_SIZE)
                    hdr_reg <= cfg_wr_data[7:0];
            end
            if (state_reg == S_INIT)
                count_reg <= NW'(1);
            else if (state_reg == S_SPL_CUR)
                count_reg <= count_reg + 1'b1;
            else if (state_reg == S_RM_RD && kr_sum >= count_ext)
                count_reg <= count_reg - NW'(r_reg);
            if (state_reg == S_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                rsize_reg     <= req_size;
                raddr_req_reg <= req_addr;
                idx_reg       <= '0;
                prev_free_reg <= 1'b0;
            end
            S_A_RD:
            begin
                res_status_reg <= ST_NO_FIT;
                res_addr_reg   <= '0;
            end
            S_A_CHK:
            begin
                if (fit)
                begin
                    cur_off_reg    <= e_off;
                    cur_size_reg   <= e_size;
                    k_reg          <= count_reg;
                    res_status_reg <= ST_OK;
                    res_addr_reg   <= e_off_w[15:0];
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_SH_WR:
            begin
                k_reg <= k_reg - 1'b1;
            end
            S_F_RD:
            begin
                res_status_reg <= ST_BAD_ADDR;
                res_addr_reg   <= '0;
                nxt_free_reg   <= 1'b0;
            end
            S_F_CHK:
            begin
                if (e_off_w == addr_w)
                begin
                    cur_off_reg  <= e_off;
                    cur_size_reg <= e_size;
                end
                else
                begin
                    prev_off_reg  <= e_off;
                    prev_size_reg <= e_size;
                    prev_free_reg <= e_free;
                    idx_reg       <= idx_reg + 1'b1;
                end
            end
            S_F_NCHK:
            begin
                nxt_free_reg <= e_free;
                nxt_size_reg <= e_size;
            end
            S_F_S1:
            begin
                merge_reg <= prev_free_reg ? s1_w[AW-1:0] : cur_size_reg;
            end
            S_F_S2:
            begin
                if (nxt_free_reg)
                    merge_reg <= s2_w[AW-1:0];
                j_reg <= prev_free_reg ? idx_reg - 1'b1 : idx_reg;
                r_reg <= {1'b0, prev_free_reg} + {1'b0, nxt_free_reg};
            end
            S_F_WR:
            begin
                k_reg          <= j_reg + 1'b1;
                res_status_reg <= ST_OK;
                res_addr_reg   <= '0;
            end
            S_RM_WR:
            begin
                k_reg <= k_reg + 1'b1;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_addr_reg   <= res_addr_reg;
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign block_addr = out_addr_reg;

endmodule

[rtl/ffba_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
